[rtl/core/rida_pkg.sv]
package rida_pkg;

   // pool geometry
   localparam int POOL_SIZE = 256;
   localparam int CELL_BITS = 16;
   localparam int NUM_CELLS = POOL_SIZE / CELL_BITS;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int BIT_W     = $clog2(CELL_BITS);
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int ID_W      = 16;
   localparam int COUNT_OUT_W = 9;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_FIRST_ID = 1'b0;
   localparam logic REG_LAST_ID  = 1'b1;
   localparam logic [ID_W-1:0] FIRST_ID_RESET = 16'd0;
   localparam logic [ID_W-1:0] LAST_ID_RESET  = 16'd255;

   typedef enum logic [1:0] {
      FUNC_ALLOC    = 2'd0,
      FUNC_FREE     = 2'd1,
      FUNC_FREE_ALL = 2'd2,
      FUNC_NOP      = 2'd3
   } func_type;

   typedef struct packed {
      func_type        func;
      logic [ID_W-1:0] release_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]        granted_id;
      logic                   granted;
      logic [COUNT_OUT_W-1:0] free_count;
   } rsp_type;

   // controller to cells
   typedef struct packed {
      logic              clear_all;
      logic              release_en;
      logic [CELL_W-1:0] rel_cell;
      logic [BIT_W-1:0]  rel_bit;
      logic [CNT_W-1:0]  size;
   } cell_ctl_type;

   // chain back to controller
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] found_idx;
      logic             fail;
      logic             hit;
   } chain_stat_type;

   // number of managed identifiers for a first/last pair
   function automatic logic [CNT_W-1:0] range_size(input logic [ID_W-1:0] first,
                                                   input logic [ID_W-1:0] last);
      logic [ID_W-1:0] diff;
      logic [CNT_W-1:0] n;
      diff = last - first;
      if (last < first) begin
         n = '0;
      end else if ({1'b0, diff} >= (ID_W+1)'(POOL_SIZE - 1)) begin
         n = CNT_W'(POOL_SIZE);
      end else begin
         n = CNT_W'(diff) + CNT_W'(1);
      end
      return n;
   endfunction

endpackage

[rtl/core/rida_cell.sv]
module rida_cell
   import rida_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CELL_W-1:0] cell_id,
   input  cell_ctl_type      ctl,
   input  logic              token_in,
   output logic              token_out,
   output logic              found,
   output logic [BIT_W-1:0]  found_bit,
   output logic              hit
);

   logic [CELL_BITS-1:0] bits_ff, bits_in;
   logic                 token_ff;
   logic [CELL_BITS-1:0] elig, free_mask, lowest, rel_mask;
   logic                 has_free, claim, rel_match;

   // eligible bits lie below the range size
   always_comb begin
      for (int b = 0; b < CELL_BITS; b++) begin
         elig[b] = CNT_W'({cell_id, BIT_W'(b)}) < ctl.size;
      end
   end

   // lowest free bit of this cell
   always_comb begin
      free_mask = ~bits_ff & elig;
      lowest    = free_mask & (~free_mask + CELL_BITS'(1));
      has_free  = |free_mask;
      found_bit = '0;
      for (int b = 0; b < CELL_BITS; b++) begin
         if (lowest[b]) begin
            found_bit = found_bit | BIT_W'(b);
         end
      end
   end

   assign claim     = token_ff && has_free;
   assign found     = claim;
   assign token_out = token_ff && !has_free;

   // release lookup
   assign rel_mask  = CELL_BITS'(1) << ctl.rel_bit;
   assign rel_match = ctl.release_en && (ctl.rel_cell == cell_id);
   assign hit       = rel_match && bits_ff[ctl.rel_bit];

   // bit update
   always_comb begin
      bits_in = bits_ff;
      if (ctl.clear_all) begin
         bits_in = '0;
      end else begin
         if (claim) begin
            bits_in = bits_in | lowest;
         end
         if (rel_match) begin
            bits_in = bits_in & ~rel_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         token_ff <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         token_ff <= token_in;
      end
   end

endmodule

[rtl/core/rida_chain.sv]
module rida_chain
   import rida_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  logic           launch,
   output chain_stat_type stat
);

   logic [NUM_CELLS:0]   token;
   logic [NUM_CELLS-1:0] found;
   logic [NUM_CELLS-1:0] hit;
   logic [BIT_W-1:0]     found_bit [NUM_CELLS];

   assign token[0] = launch;

   // row of cells, the search token walks one cell per cycle
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rida_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_W'(i)),
         .ctl       (ctl),
         .token_in  (token[i]),
         .token_out (token[i+1]),
         .found     (found[i]),
         .found_bit (found_bit[i]),
         .hit       (hit[i])
      );
   end

   // at most one cell reports per cycle
   always_comb begin
      stat.found_idx = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (found[i]) begin
            stat.found_idx = stat.found_idx | {CELL_W'(i), found_bit[i]};
         end
      end
      stat.found = |found;
      stat.hit   = |hit;
      stat.fail  = token[NUM_CELLS];
   end

endmodule

[rtl/core/range_id_allocator.sv]
// free, free-all and no-op words register their result in the exec state when the output
// register is free; an allocate launches the search token there, down the cell row, and
// registers its result in the scan state when the token finds a free bit or exits the row
// words are taken only when idle, also while a result still waits in the output register
// reset (synchronous): all identifiers free, first_id 0, last_id 255, free count 256
// a register write also frees every identifier and reloads the count with the range size
module range_id_allocator
   import rida_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  first_id_ff, first_id_in;
   logic [ID_W-1:0]  last_id_ff, last_id_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] count_ff, count_in;
   func_type         func_ff;
   logic             rel_ok_ff, rel_ok_in;
   logic [IDX_W-1:0] rel_idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;

   logic             cfg_wr, req_accept, slot_free, launch, free_all;
   logic [ID_W:0]    rel_diff;
   cell_ctl_type     ctl;
   chain_stat_type   stat;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_LAST_ID) ? {16'd0, last_id_ff} : {16'd0, first_id_ff};

   always_comb begin
      first_id_in = first_id_ff;
      last_id_in  = last_id_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_FIRST_ID: first_id_in = csr_pwdata[ID_W-1:0];
            REG_LAST_ID:  last_id_in  = csr_pwdata[ID_W-1:0];
            default:      first_id_in = first_id_ff;
         endcase
      end
      size_in = cfg_wr ? range_size(first_id_in, last_id_in) : size_ff;
   end

   // handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // release index relative to the range start
   assign rel_diff  = {1'b0, req_word.release_id} - {1'b0, first_id_ff};
   assign rel_ok_in = !rel_diff[ID_W] && (rel_diff[ID_W-1:0] < (ID_W)'(size_ff));

   // cell control
   assign launch   = (state_ff == ST_EXEC) && slot_free && (func_ff == FUNC_ALLOC);
   assign free_all = (state_ff == ST_EXEC) && slot_free && (func_ff == FUNC_FREE_ALL);

   always_comb begin
      ctl.clear_all  = cfg_wr || free_all;
      ctl.release_en = (state_ff == ST_EXEC) && slot_free && (func_ff == FUNC_FREE) && rel_ok_ff;
      ctl.rel_cell   = rel_idx_ff[IDX_W-1:BIT_W];
      ctl.rel_bit    = rel_idx_ff[BIT_W-1:0];
      ctl.size       = size_ff;
   end

   rida_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .launch (launch),
      .stat   (stat)
   );

   // sequencer and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               unique case (func_ff)
                  FUNC_ALLOC: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_FREE: begin
                     if (stat.hit) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     state_in = ST_IDLE;
                  end
                  FUNC_FREE_ALL: begin
                     count_in = size_ff;
                     state_in = ST_IDLE;
                  end
                  FUNC_NOP: begin
                     state_in = ST_IDLE;
                  end
               endcase
               if (func_ff != FUNC_ALLOC) begin
                  rsp_valid_in           = 1'b1;
                  rsp_word_in.granted_id = '0;
                  rsp_word_in.granted    = 1'b0;
                  rsp_word_in.free_count = COUNT_OUT_W'(count_in);
               end
            end
         end
         ST_SCAN: begin
            if (stat.found || stat.fail) begin
               if (stat.found && (count_ff != '0)) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in           = 1'b1;
               rsp_word_in.granted    = stat.found;
               rsp_word_in.granted_id = stat.found ? first_id_ff + ID_W'(stat.found_idx) : '0;
               rsp_word_in.free_count = COUNT_OUT_W'(count_in);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // register write reloads the count
      if (cfg_wr) begin
         count_in = size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_id_ff  <= FIRST_ID_RESET;
         last_id_ff   <= LAST_ID_RESET;
         size_ff      <= range_size(FIRST_ID_RESET, LAST_ID_RESET);
         count_ff     <= range_size(FIRST_ID_RESET, LAST_ID_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_id_ff  <= first_id_in;
         last_id_ff   <= last_id_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command capture and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff    <= req_word.func;
         rel_ok_ff  <= rel_ok_in;
         rel_idx_ff <= rel_diff[IDX_W-1:0];
      end
      rsp_word_ff <= rsp_word_in;
   end

   // free count never exceeds the range size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= size_ff)
      else $error("free count above range size");

   // search reports only during a scan
   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      (stat.found || stat.fail) |-> (state_ff == ST_SCAN))
      else $error("chain report outside scan");

   // a search ends either found or failed, never both
   a_found_fail: assert property (@(posedge clock) disable iff (reset)
      !(stat.found && stat.fail))
      else $error("chain found and failed together");

   // a grant takes exactly one identifier off the count
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stat.found && !cfg_wr) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("grant did not decrement count");

endmodule

[test/range_id_allocator_tb.sv]
module range_id_allocator_tb;
   import rida_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_WORDS = 1200;
   localparam int PHASE_WORDS  = 150;

   // one line of the directed script: a register write or a request word
   typedef struct {
      bit               csr_row;
      logic             reg_sel;
      logic [ID_W-1:0]  value;
      func_type         func;
      bit               typed;
      rsp_type          want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow of the allocator state
   logic [ID_W-1:0]       shadow_first = FIRST_ID_RESET;
   logic [ID_W-1:0]       shadow_last = LAST_ID_RESET;
   logic [POOL_SIZE-1:0]  shadow_in_use = '0;
   int unsigned           shadow_avail = POOL_SIZE;

   rsp_type               pending_rsp_q[$];
   script_row_type        directed_q[$];
   rsp_type               oldest_rsp;

   int errors = 0;
   int words_sent = 0;
   int random_sent = 0;
   int results_seen = 0;
   int grant_count = 0;
   int denial_count = 0;
   int send_idle_pct = 11;
   int rsp_stall_pct = 68;
   int quiet_cycles = 0;

   range_id_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock generation
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // number of identifiers managed for the current first/last pair
   function automatic int unsigned managed_span();
      int unsigned n;
      if (shadow_last < shadow_first) return 0;
      n = int'(shadow_last) - int'(shadow_first) + 1;
      if (n > POOL_SIZE) n = POOL_SIZE;
      return n;
   endfunction

   function automatic void shadow_clear();
      shadow_in_use = '0;
      shadow_avail = managed_span();
   endfunction

   // apply one request word to the shadow and return the result it gives
   function automatic rsp_type apply_word(req_type w);
      rsp_type r;
      int unsigned n;
      int unsigned k;
      r = '0;
      n = managed_span();
      case (w.func)
         FUNC_ALLOC: begin
            for (k = 0; k < n; k++) begin
               if (!shadow_in_use[k]) begin
                  shadow_in_use[k] = 1'b1;
                  if (shadow_avail > 0) shadow_avail--;
                  r.granted_id = ID_W'(int'(shadow_first) + k);
                  r.granted = 1'b1;
                  break;
               end
            end
            if (r.granted) grant_count++;
            else denial_count++;
         end
         FUNC_FREE: begin
            if (w.release_id >= shadow_first) begin
               k = int'(w.release_id) - int'(shadow_first);
               if (k < n && shadow_in_use[k]) begin
                  shadow_in_use[k] = 1'b0;
                  shadow_avail++;
               end
            end
         end
         FUNC_FREE_ALL: begin
            shadow_clear();
         end
         default: begin
         end
      endcase
      r.free_count = COUNT_OUT_W'(shadow_avail);
      return r;
   endfunction

   // script builders
   function automatic void add_op(func_type f, logic [ID_W-1:0] id);
      script_row_type row;
      row = '{0, REG_FIRST_ID, id, f, 0, '0};
      directed_q.push_back(row);
   endfunction

   function automatic void add_checked(func_type f, logic [ID_W-1:0] id,
                                       logic [ID_W-1:0] gid, logic ok,
                                       logic [COUNT_OUT_W-1:0] cnt);
      script_row_type row;
      row = '{0, REG_FIRST_ID, id, f, 1, '{gid, ok, cnt}};
      directed_q.push_back(row);
   endfunction

   function automatic void add_csr(logic sel, logic [ID_W-1:0] value);
      script_row_type row;
      row = '{1, sel, value, FUNC_NOP, 0, '0};
      directed_q.push_back(row);
   endfunction

   // offer one word, optionally idling first, and record its result
   task automatic send_word(req_type w, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predicted = apply_word(w);
      pending_rsp_q.push_back(typed ? want : predicted);
      words_sent++;
      if (words_sent == 400) begin
         send_idle_pct = 68;
         rsp_stall_pct = 11;
      end else if (words_sent == 800) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
   endtask

   // hold off until every result is back and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back
   task automatic csr_write(logic sel, logic [ID_W-1:0] value);
      logic [31:0] back;
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      back = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (back[ID_W-1:0] !== value) begin
         $error("register %0d: expected %0d, got %0d", sel, value, back[ID_W-1:0]);
         errors++;
      end
      if (sel == REG_FIRST_ID) shadow_first = value;
      else shadow_last = value;
      shadow_clear();
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected result word %p", rsp_word);
            errors++;
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            results_seen++;
            if (rsp_word.granted_id !== oldest_rsp.granted_id) begin
               $error("granted_id: expected %0d, got %0d",
                      oldest_rsp.granted_id, rsp_word.granted_id);
               errors++;
            end
            if (rsp_word.granted !== oldest_rsp.granted) begin
               $error("granted: expected %0d, got %0d", oldest_rsp.granted, rsp_word.granted);
               errors++;
            end
            if (rsp_word.free_count !== oldest_rsp.free_count) begin
               $error("free_count: expected %0d, got %0d",
                      oldest_rsp.free_count, rsp_word.free_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      script_row_type row;
      req_type w;
      int unsigned n;
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      int ph;
      int j;

      // reset range 0..255: no-op, free of an unused identifier, allocate, free, refill, free-all
      add_checked(FUNC_NOP, 16'hFFFF, 16'd0, 1'b0, 9'd256);
      add_checked(FUNC_FREE, 16'd0, 16'd0, 1'b0, 9'd256);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b1, 9'd255);
      add_checked(FUNC_ALLOC, 16'hAAAA, 16'd1, 1'b1, 9'd254);
      add_checked(FUNC_FREE, 16'd0, 16'd0, 1'b0, 9'd255);
      add_checked(FUNC_ALLOC, 16'h5555, 16'd0, 1'b1, 9'd254);
      add_checked(FUNC_FREE, 16'hFFFF, 16'd0, 1'b0, 9'd254);
      add_checked(FUNC_FREE_ALL, 16'd0, 16'd0, 1'b0, 9'd256);
      add_checked(FUNC_FREE, 16'd255, 16'd0, 1'b0, 9'd256);
      // empty range: first above last
      add_csr(REG_FIRST_ID, 16'hFFFF);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b0, 9'd0);
      // single identifier at the top of the space
      add_csr(REG_LAST_ID, 16'hFFFF);
      add_checked(FUNC_ALLOC, 16'd0, 16'hFFFF, 1'b1, 9'd0);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b0, 9'd0);
      add_checked(FUNC_FREE, 16'hFFFF, 16'd0, 1'b0, 9'd1);
      // oversized range capped at pool size
      add_csr(REG_FIRST_ID, 16'd0);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b1, 9'd255);
      add_checked(FUNC_FREE, 16'd256, 16'd0, 1'b0, 9'd255);
      add_checked(FUNC_FREE, 16'd255, 16'd0, 1'b0, 9'd255);
      // single identifier zero
      add_csr(REG_LAST_ID, 16'd0);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b1, 9'd0);
      add_checked(FUNC_ALLOC, 16'd0, 16'd0, 1'b0, 9'd0);
      add_checked(FUNC_FREE_ALL, 16'd0, 16'd0, 1'b0, 9'd1);
      // small offset range
      add_csr(REG_FIRST_ID, 16'd100);
      add_csr(REG_LAST_ID, 16'd102);
      add_op(FUNC_ALLOC, 16'd0);
      add_op(FUNC_ALLOC, 16'd0);
      add_op(FUNC_FREE, 16'd101);
      add_op(FUNC_ALLOC, 16'd0);
      add_op(FUNC_ALLOC, 16'd0);
      add_op(FUNC_ALLOC, 16'd0);
      add_op(FUNC_NOP, 16'd102);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (directed_q[i]) begin
         row = directed_q[i];
         if (row.csr_row) begin
            csr_write(row.reg_sel, row.value);
         end else begin
            w.func = row.func;
            w.release_id = row.value;
            send_word(w, row.typed, row.want);
         end
      end

      // random phases, each with its own range
      for (ph = 0; random_sent < RANDOM_WORDS; ph++) begin
         case (ph % 4)
            0: begin
               lo = $urandom_range(16'hFFFF);
               hi = lo + $urandom_range(20);
            end
            1: begin
               lo = $urandom_range(300);
               hi = lo + $urandom_range(400, 200);
            end
            2: begin
               lo = $urandom_range(16'hFFFF);
               hi = $urandom_range(16'hFFFF);
            end
            default: begin
               lo = $urandom_range(1000);
               hi = lo + $urandom_range(7);
            end
         endcase
         if (hi > 16'hFFFF) hi = 16'hFFFF;
         if ($urandom_range(1)) begin
            csr_write(REG_FIRST_ID, ID_W'(lo));
            csr_write(REG_LAST_ID, ID_W'(hi));
         end else begin
            csr_write(REG_LAST_ID, ID_W'(hi));
            csr_write(REG_FIRST_ID, ID_W'(lo));
         end

         // allocation-heavy first half fills the pool, second half drains it
         for (j = 0; j < PHASE_WORDS && random_sent < RANDOM_WORDS; j++) begin
            pick = $urandom_range(99);
            n = managed_span();
            w.release_id = ID_W'($urandom_range(16'hFFFF));
            if (pick < ((j < PHASE_WORDS / 2) ? 65 : 35)) begin
               w.func = FUNC_ALLOC;
            end else if (pick < 94) begin
               w.func = FUNC_FREE;
               if (n > 0 && $urandom_range(99) < 85)
                  w.release_id = ID_W'(int'(shadow_first) + $urandom_range(n + 1));
            end else if (pick < 97) begin
               w.func = FUNC_FREE_ALL;
            end else begin
               w.func = FUNC_NOP;
            end
            send_word(w, 0, '0);
            random_sent++;
         end
      end

      wait_idle();
      $display("run covered %0d words in %0d range settings, %0d results checked",
               words_sent, ph, results_seen);
      $display("allocations granted %0d, denied %0d, mismatches %0d",
               grant_count, denial_count, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
